/* design/wts_pkg.sv */
package wts_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_FLUSH,
      ST_DIV,
      ST_OUT
   } state_type;

   // per-voice slots, one wave ram read issued in each
   typedef enum logic [2:0] {
      STEP_ISSUE,
      STEP_FREQ_LO,
      STEP_FREQ_MID,
      STEP_FREQ_HI,
      STEP_WSEL,
      STEP_AMP,
      STEP_CTL,
      STEP_SAMPLE
   } step_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam int RAM_AW    = 11;
   localparam int RAM_DEPTH = 2048;
   localparam int BYTE_W    = 8;
   localparam int PHASE_W   = 24;
   localparam int VOICE_W   = PHASE_W + BYTE_W;
   localparam int LIN_W     = 13;
   localparam int PROD_W    = 16;
   localparam int ACC_W     = 21;
   localparam int MAG_W     = 20;
   localparam int QUO_W     = 17;
   localparam int OUT_W     = 18;

   localparam logic [15:0] PAGE_ADDR     = 16'hFCFF;
   localparam logic [7:0]  RAM_PAGE      = 8'hFD;
   localparam logic [3:0]  CTRL_PAGE_NIB = 4'hE;
   localparam logic [2:0]  CTRL_HI       = 3'b111;
   localparam logic [6:0]  DISABLE_ROW   = 7'h70;
   localparam logic [3:0]  SELECT_RESET  = 4'd3;

   // control row offsets (address bits 6..4)
   localparam logic [2:0] OFS_FREQ_LO  = 3'd0;
   localparam logic [2:0] OFS_FREQ_MID = 3'd1;
   localparam logic [2:0] OFS_FREQ_HI  = 3'd2;
   localparam logic [2:0] OFS_WSEL     = 3'd5;
   localparam logic [2:0] OFS_AMP      = 3'd6;
   localparam logic [2:0] OFS_CTL      = 3'd7;

   // x / 6 == (x * RECIP6) >> RECIP_SHIFT for x < 2**20
   localparam logic [20:0] RECIP6      = 21'd1398102;
   localparam int          RECIP_SHIFT = 23;

   localparam logic [2:0] PAN_FULL = 3'd6;

   function automatic logic [2:0] pan_weight(input logic [3:0] code);
      logic [2:0] w;
      case (code)
         4'd8, 4'd9, 4'd10: w = 3'd6;
         4'd11:             w = 3'd5;
         4'd12:             w = 3'd4;
         4'd13:             w = 3'd3;
         4'd14:             w = 3'd2;
         4'd15:             w = 3'd1;
         default:           w = 3'd0;
      endcase
      return w;
   endfunction

   // ((2s+33) << c) - 33
   function automatic logic [LIN_W-1:0] antilog(input logic [6:0] v);
      logic [LIN_W-1:0] t;
      t = LIN_W'({v[3:0], 1'b1}) + LIN_W'(32);
      return (t << v[6:4]) - LIN_W'(33);
   endfunction

endpackage

/* design/wts_ram.sv */
module wts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/wavetable_synth_16ch.sv */
// Sixteen-voice wavetable synthesizer with a host bus front end. A word on the request
// channel is either a bus write (cmd 0) or a sample tick (cmd 1). A write to 0xFCFF loads
// the page register; a write to 0xFDxx lands in the 2 KiB wave/control ram when the page
// high nibble equals synth_select. A tick steps every voice and returns one stereo word
// on the response channel. Each voice runs seven reads of the single-read-port wave ram
// (three frequency bytes, wave select, amplitude, control, wave sample) and one slot in
// which the modulate flag settles. Voices run strictly one after another because the
// modulate flag of one voice picks the control bank of the next. Phase and amplitude
// latches live in a small per-voice ram. After reset the block clears the wave ram and
// stalls requests meanwhile; csr writes are taken at any time. The request channel is
// free again while a finished stereo word waits on a stalled response channel.
module wavetable_synth_16ch
   import wts_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   input  logic [15:0]             req_addr,
   input  logic [7:0]              req_wdata,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_left,
   output logic signed [OUT_W-1:0] rsp_right,
   // csr channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [3:0]              csr_synth_select
);

   localparam int VW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // control state
   state_type         state_ff, state_in;
   step_type          step_ff, step_in;
   logic [VW-1:0]     vidx_ff, vidx_in;
   logic [RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              mod_ff, mod_in;
   logic [7:0]        page_ff, page_in;
   logic [3:0]        select_ff, select_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              acc_en_ff, acc_en_in;

   // per-voice datapath
   logic [PHASE_W-1:0] freq_ff, freq_in;
   logic               dis_ff, dis_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  amp_old_ff, amp_old_in;
   logic [3:0]         wsel_ff, wsel_in;
   logic [PHASE_W-1:0] sum_ff, sum_in;
   logic               carry_ff, carry_in;
   logic [BYTE_W-1:0]  amp_ff, amp_in;
   logic [5:0]         ctl_ff, ctl_in;
   logic [6:0]         mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [2:0]         pan_ff, pan_in;

   // mix and output
   logic signed [ACC_W-1:0] acc_l_ff, acc_l_in;
   logic signed [ACC_W-1:0] acc_r_ff, acc_r_in;
   logic [QUO_W-1:0]        quo_l_ff, quo_l_in;
   logic [QUO_W-1:0]        quo_r_ff, quo_r_in;
   logic signed [OUT_W-1:0] left_ff, left_in;
   logic signed [OUT_W-1:0] right_ff, right_in;

   // memory ports
   logic               wave_we;
   logic [RAM_AW-1:0]  wave_waddr;
   logic [BYTE_W-1:0]  wave_wdata;
   logic [RAM_AW-1:0]  wave_raddr;
   logic [BYTE_W-1:0]  wave_rdata;
   logic               voice_we;
   logic [VW-1:0]      voice_waddr;
   logic [VOICE_W-1:0] voice_wdata;
   logic [VOICE_W-1:0] voice_rdata;

   // handshake and decode
   logic req_accept;
   logic tick_accept;
   logic write_accept;
   logic last_voice;
   logic out_load;
   logic [2:0] row_ofs;

   // per-voice combinational helpers
   logic [PHASE_W:0]    sum_full;
   logic [BYTE_W-1:0]   smp_sum;
   logic                smp_sign;
   logic [LIN_W-1:0]    lin;
   logic [PROD_W-1:0]   prod_l;
   logic [PROD_W-1:0]   prod_r;
   logic [MAG_W-1:0]    abs_l;
   logic [MAG_W-1:0]    abs_r;
   logic [MAG_W+20:0]   recip_l;
   logic [MAG_W+20:0]   recip_r;

   // wave and control ram: one write port, one registered read port
   wts_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(RAM_DEPTH)
   ) u_wave_ram (
      .clock  (clock),
      .wr_en  (wave_we),
      .wr_addr(wave_waddr),
      .wr_data(wave_wdata),
      .rd_addr(wave_raddr),
      .rd_data(wave_rdata)
   );

   // phase accumulator and amplitude latch, one word per voice
   wts_ram #(
      .WIDTH(VOICE_W),
      .DEPTH(CHANNELS)
   ) u_voice_ram (
      .clock  (clock),
      .wr_en  (voice_we),
      .wr_addr(voice_waddr),
      .wr_data(voice_wdata),
      .rd_addr(vidx_ff),
      .rd_data(voice_rdata)
   );

   assign req_accept   = req_valid && !req_stall;
   assign tick_accept  = req_accept && (req_cmd == CMD_TICK);
   assign write_accept = req_accept && (req_cmd == CMD_WRITE);
   assign last_voice   = (vidx_ff == VW'(CHANNELS - 1));
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready    = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == RAM_AW'(RAM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (tick_accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if ((step_ff == STEP_SAMPLE) && last_voice) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_DIV;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // which control row the current slot reads
   always_comb begin
      case (step_ff)
         STEP_ISSUE:    row_ofs = OFS_FREQ_LO;
         STEP_FREQ_LO:  row_ofs = OFS_FREQ_MID;
         STEP_FREQ_MID: row_ofs = OFS_FREQ_HI;
         STEP_FREQ_HI:  row_ofs = OFS_WSEL;
         STEP_WSEL:     row_ofs = OFS_AMP;
         STEP_AMP:      row_ofs = OFS_CTL;
         default:       row_ofs = OFS_FREQ_LO;
      endcase
   end

   // state outputs: request stall and memory ports
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      wave_we     = 1'b0;
      wave_waddr  = clr_cnt_ff;
      wave_wdata  = '0;
      voice_we    = 1'b0;
      voice_waddr = vidx_ff;
      voice_wdata = {sum_ff, amp_ff};
      // bank chosen by the modulate flag, voice in the low nibble
      wave_raddr  = {CTRL_HI, mod_ff, row_ofs, 4'(vidx_ff)};
      case (state_ff)
         ST_CLEAR: begin
            // zero everything, voice disable row to one
            wave_we    = 1'b1;
            wave_wdata = BYTE_W'(clr_cnt_ff[RAM_AW-1:4] == DISABLE_ROW);
            voice_we   = (clr_cnt_ff < RAM_AW'(CHANNELS));
            voice_waddr = clr_cnt_ff[VW-1:0];
            voice_wdata = '0;
         end
         ST_IDLE: begin
            if (write_accept && (req_addr != PAGE_ADDR) && (page_ff[7:4] == select_ff)
                && (req_addr[15:8] == RAM_PAGE)) begin
               wave_we    = 1'b1;
               wave_wdata = req_wdata;
               if (page_ff[3:0] == CTRL_PAGE_NIB) begin
                  wave_waddr = {CTRL_HI, req_addr[7:0]};
               end else begin
                  wave_waddr = {page_ff[3:1], req_addr[7:0]};
               end
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_CTL) begin
               // wave sample fetch and phase/amp write back
               wave_raddr = {wsel_ff, sum_ff[PHASE_W-1:PHASE_W-7]};
               voice_we   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_comb begin
      step_in      = step_ff;
      vidx_in      = vidx_ff;
      clr_cnt_in   = clr_cnt_ff;
      page_in      = page_ff;
      select_in    = select_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (tick_accept) begin
         step_in = STEP_ISSUE;
         vidx_in = '0;
      end
      if (state_ff == ST_RUN) begin
         step_in = step_type'(step_ff + 1'b1);
         if ((step_ff == STEP_SAMPLE) && !last_voice) begin
            vidx_in = vidx_ff + 1'b1;
         end
      end
      if (write_accept && (req_addr == PAGE_ADDR)) begin
         page_in = req_wdata;
      end
      if (csr_valid && csr_ready) begin
         select_in = csr_synth_select;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // voice datapath
   always_comb begin
      freq_in    = freq_ff;
      dis_in     = dis_ff;
      phase_in   = phase_ff;
      amp_old_in = amp_old_ff;
      wsel_in    = wsel_ff;
      sum_in     = sum_ff;
      carry_in   = carry_ff;
      amp_in     = amp_ff;
      ctl_in     = ctl_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      pan_in     = pan_ff;
      mod_in     = mod_ff;
      acc_en_in  = 1'b0;

      // phase step, disable bit drops the old phase
      sum_full = (dis_ff ? (PHASE_W + 1)'(0) : (PHASE_W + 1)'(phase_ff))
                 + (PHASE_W + 1)'(freq_ff);
      // wave byte plus amplitude in log domain, 8-bit wrap
      smp_sign = wave_rdata[7];
      smp_sum  = wave_rdata + amp_ff;

      if (state_ff == ST_RUN) begin
         case (step_ff)
            STEP_FREQ_LO: begin
               freq_in[7:0] = wave_rdata;
               dis_in       = wave_rdata[0];
               phase_in     = voice_rdata[VOICE_W-1:BYTE_W];
               amp_old_in   = voice_rdata[BYTE_W-1:0];
            end
            STEP_FREQ_MID: freq_in[15:8]  = wave_rdata;
            STEP_FREQ_HI:  freq_in[23:16] = wave_rdata;
            STEP_WSEL: begin
               wsel_in  = wave_rdata[7:4];
               sum_in   = sum_full[PHASE_W-1:0];
               carry_in = sum_full[PHASE_W];
            end
            STEP_AMP: begin
               // amplitude latched on phase wrap only
               amp_in = carry_ff ? wave_rdata : amp_old_ff;
            end
            STEP_CTL: ctl_in = wave_rdata[5:0];
            STEP_SAMPLE: begin
               mod_in    = ctl_ff[5] && (smp_sign || carry_ff);
               // a sum that stays on the sign side of the wave byte gives zero magnitude
               mag_in    = (smp_sign ^ smp_sum[7]) ? smp_sum[6:0] : 7'd0;
               neg_in    = smp_sign ^ ctl_ff[4];
               pan_in    = pan_weight(ctl_ff[3:0]);
               acc_en_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // antilog, pan and mix, one voice behind the sequencer
   always_comb begin
      lin      = antilog(mag_ff);
      prod_l   = PROD_W'(lin * pan_ff);
      prod_r   = PROD_W'(lin * 3'(PAN_FULL - pan_ff));
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (tick_accept) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (acc_en_ff) begin
         if (neg_ff) begin
            acc_l_in = acc_l_ff - signed'(ACC_W'(prod_l));
            acc_r_in = acc_r_ff - signed'(ACC_W'(prod_r));
         end else begin
            acc_l_in = acc_l_ff + signed'(ACC_W'(prod_l));
            acc_r_in = acc_r_ff + signed'(ACC_W'(prod_r));
         end
      end
   end

   // divide by six on magnitudes, truncation toward zero
   always_comb begin
      abs_l    = acc_l_ff[ACC_W-1] ? MAG_W'(-acc_l_ff) : MAG_W'(acc_l_ff);
      abs_r    = acc_r_ff[ACC_W-1] ? MAG_W'(-acc_r_ff) : MAG_W'(acc_r_ff);
      recip_l  = (MAG_W + 21)'(abs_l) * (MAG_W + 21)'(RECIP6);
      recip_r  = (MAG_W + 21)'(abs_r) * (MAG_W + 21)'(RECIP6);
      quo_l_in = quo_l_ff;
      quo_r_in = quo_r_ff;
      if (state_ff == ST_DIV) begin
         quo_l_in = recip_l[RECIP_SHIFT +: QUO_W];
         quo_r_in = recip_r[RECIP_SHIFT +: QUO_W];
      end
      left_in  = left_ff;
      right_in = right_ff;
      if (out_load) begin
         left_in  = acc_l_ff[ACC_W-1] ? -signed'(OUT_W'(quo_l_ff)) : signed'(OUT_W'(quo_l_ff));
         right_in = acc_r_ff[ACC_W-1] ? -signed'(OUT_W'(quo_r_ff)) : signed'(OUT_W'(quo_r_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_ISSUE;
         vidx_ff      <= '0;
         clr_cnt_ff   <= '0;
         mod_ff       <= 1'b0;
         page_ff      <= '0;
         select_ff    <= SELECT_RESET;
         rsp_valid_ff <= 1'b0;
         acc_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         vidx_ff      <= vidx_in;
         clr_cnt_ff   <= clr_cnt_in;
         mod_ff       <= mod_in;
         page_ff      <= page_in;
         select_ff    <= select_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_en_ff    <= acc_en_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff    <= freq_in;
      dis_ff     <= dis_in;
      phase_ff   <= phase_in;
      amp_old_ff <= amp_old_in;
      wsel_ff    <= wsel_in;
      sum_ff     <= sum_in;
      carry_ff   <= carry_in;
      amp_ff     <= amp_in;
      ctl_ff     <= ctl_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      pan_ff     <= pan_in;
      acc_l_ff   <= acc_l_in;
      acc_r_ff   <= acc_r_in;
      quo_l_ff   <= quo_l_in;
      quo_r_ff   <= quo_r_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left  = left_ff;
   assign rsp_right = right_ff;

endmodule

/* bench/stereo_check_pkg.sv */
package stereo_check_pkg;
   import wts_pkg::*;

   typedef struct {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
   } frame_type;

   localparam int CTRL_ROW = 1792;
   localparam int VOICES   = 16;

   class stereo_scoreboard;
      logic [3:0]  select_q;
      logic [7:0]  page_q;
      logic [7:0]  wave_mem [RAM_DEPTH];
      logic [23:0] phase_q [VOICES];
      logic [7:0]  amp_q [VOICES];
      bit          bank_q;
      frame_type   frames_due [$];
      int          errors;

      function new();
         select_q = SELECT_RESET;
         page_q   = '0;
         bank_q   = 1'b0;
         errors   = 0;
         foreach (wave_mem[i])
            wave_mem[i] = (i >= CTRL_ROW && i < CTRL_ROW + VOICES) ? 8'd1 : 8'd0;
         foreach (phase_q[i]) begin
            phase_q[i] = '0;
            amp_q[i]   = '0;
         end
      endfunction

      function int pan_of(int code);
         if (code < 8)
            return 0;
         if (code < 11)
            return 6;
         return 16 - code;
      endfunction

      // one tick: step all voices and queue the stereo frame
      function void mix_voices();
         int          left_sum, right_sum, lin, w;
         int unsigned base, freq, sum, carry, ctl, smp, sgn, mag, s, c;
         logic [10:0] idx;
         frame_type   f;
         left_sum  = 0;
         right_sum = 0;
         for (int v = 0; v < VOICES; v++) begin
            base  = CTRL_ROW + (bank_q ? 128 : 0) + v;
            freq  = {8'd0, wave_mem[base+32], wave_mem[base+16], wave_mem[base]};
            sum   = (wave_mem[base][0] ? 32'd0 : {8'd0, phase_q[v]}) + freq;
            carry = sum[24];
            ctl   = {24'd0, wave_mem[base+112]};
            phase_q[v] = sum[23:0];
            idx   = {wave_mem[base+80][7:4], phase_q[v][23:17]};
            smp   = {24'd0, wave_mem[idx]};
            if (carry != 0)
               amp_q[v] = wave_mem[base+96];
            sgn   = smp & 32'h80;
            smp   = smp + {24'd0, amp_q[v]};
            bank_q = ctl[5] && (sgn != 0 || carry != 0);
            mag   = (((sgn ^ smp) & 32'h80) != 0) ? (smp & 32'h7F) : 32'd0;
            if (ctl[4])
               sgn = sgn ^ 32'h80;
            s     = mag & 32'd15;
            c     = (mag >> 4) & 32'd7;
            lin   = int'(((2 * s + 33) << c) - 33);
            if (sgn != 0)
               lin = -lin;
            w     = pan_of(int'(ctl & 32'd15));
            left_sum  += lin * w;
            right_sum += lin * (6 - w);
         end
         f.left  = OUT_W'(left_sum / 6);
         f.right = OUT_W'(right_sum / 6);
         frames_due.push_back(f);
      endfunction

      // returns 1 when the word changes state or makes a frame
      function bit note_word(logic cmd, logic [15:0] addr, logic [7:0] data);
         logic [10:0] dst;
         if (cmd == CMD_TICK) begin
            mix_voices();
            return 1'b1;
         end
         if (addr == PAGE_ADDR) begin
            page_q = data;
            return 1'b1;
         end
         if (page_q[7:4] != select_q || addr[15:8] != RAM_PAGE)
            return 1'b0;
         if (page_q[3:0] == CTRL_PAGE_NIB)
            dst = {CTRL_HI, addr[7:0]};
         else
            dst = {page_q[3:1], addr[7:0]};
         wave_mem[dst] = data;
         return 1'b1;
      endfunction

      function void check_frame(logic signed [OUT_W-1:0] left, logic signed [OUT_W-1:0] right);
         frame_type want;
         if (frames_due.size() == 0) begin
            $error("stereo word with no frame expected: left %0d right %0d", left, right);
            errors++;
            return;
         end
         want = frames_due.pop_front();
         if (left !== want.left) begin
            $error("left mismatch: expected %0d, actual %0d", want.left, left);
            errors++;
         end
         if (right !== want.right) begin
            $error("right mismatch: expected %0d, actual %0d", want.right, right);
            errors++;
         end
      endfunction

      function int pending();
         return frames_due.size();
      endfunction
   endclass

endpackage

/* bench/tb_top.sv */
module tb_top;
   import wts_pkg::*;
   import stereo_check_pkg::*;

   // run length and timing budget
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_WORDS   = 1650;
   localparam int SETTLE_CYCLES  = 140;   // one full tick plus margin
   localparam int END_CYCLES     = 200;
   localparam logic [3:0] CTRL_ALIAS_NIB = 4'hF;  // page low nibble that also hits control
   localparam int WAVE_NIB_MAX   = 13;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_cmd;
   logic [15:0]             req_addr;
   logic [7:0]              req_wdata;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [OUT_W-1:0] rsp_left;
   logic signed [OUT_W-1:0] rsp_right;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [3:0]              csr_synth_select;

   stereo_scoreboard sb;
   int               sender_idle_pct;
   int               rsp_stall_pct;
   int               words_done;
   int               base_words;
   logic [3:0]       cur_select;

   wavetable_synth_16ch uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_addr         (req_addr),
      .req_wdata        (req_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left         (rsp_left),
      .rsp_right        (rsp_right),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_synth_select (csr_synth_select)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop if the block hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // response side back-pressure, redrawn every falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // every accepted stereo word goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_frame(rsp_left, rsp_right);
   end

   function automatic logic [7:0] rand_byte();
      int unsigned r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic logic [15:0] rand_addr();
      int unsigned r;
      r = $urandom;
      return r[15:0];
   endfunction

   // present one request word, hold it until taken; called and returns at a falling edge
   task automatic send_word(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_addr  <= addr;
      req_wdata <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (sb.note_word(cmd, addr, data))
         words_done++;
      @(negedge clock);
   endtask

   task automatic ram_word(input logic [7:0] lo, input logic [7:0] data);
      send_word(CMD_WRITE, {RAM_PAGE, lo}, data);
   endtask

   task automatic page_word(input logic [7:0] data);
      send_word(CMD_WRITE, PAGE_ADDR, data);
   endtask

   // stop sending, let every frame drain, then let the pipe go quiet
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   // csr write only with the block idle
   task automatic write_select(input logic [3:0] sel);
      settle(SETTLE_CYCLES);
      csr_valid        <= 1'b1;
      csr_synth_select <= sel;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.select_q = sel;
      cur_select  = sel;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // page onto the control ram, then program random voice bytes in either bank
   task automatic control_burst();
      logic [3:0] nib;
      nib = ($urandom_range(3) == 0) ? CTRL_ALIAS_NIB : CTRL_PAGE_NIB;
      page_word({cur_select, nib});
      repeat ($urandom_range(12, 1))
         ram_word(rand_byte(), rand_byte());
   endtask

   // page onto one of the wave blocks below control and fill random bytes
   task automatic wave_burst();
      int unsigned r;
      r = $urandom_range(WAVE_NIB_MAX);
      page_word({cur_select, r[3:0]});
      repeat ($urandom_range(16, 1))
         ram_word(rand_byte(), rand_byte());
   endtask

   task automatic tick_run();
      repeat ($urandom_range(6, 1))
         send_word(CMD_TICK, rand_addr(), rand_byte());
   endtask

   // stray writes: any address, a random page, or ram writes under whatever page
   task automatic noise_word();
      case ($urandom_range(2))
         0: send_word(CMD_WRITE, rand_addr(), rand_byte());
         1: page_word(rand_byte());
         default: ram_word(rand_byte(), rand_byte());
      endcase
   endtask

   task automatic run_random(input int target);
      int unsigned pick;
      while (words_done < target) begin
         pick = $urandom_range(99);
         if (pick < 25)
            control_burst();
         else if (pick < 40)
            wave_burst();
         else if (pick < 80)
            tick_run();
         else
            repeat ($urandom_range(3, 1)) noise_word();
      end
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_WRITE;
      req_addr         = '0;
      req_wdata        = '0;
      csr_valid        = 1'b0;
      csr_synth_select = SELECT_RESET;
      sender_idle_pct  = 0;
      rsp_stall_pct    = 0;
      words_done       = 0;
      cur_select       = SELECT_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // requests wait out the ram clear through req_stall
      write_select(SELECT_RESET);

      // all voices disabled after reset: silent frame
      send_word(CMD_TICK, 16'h0000, 8'h00);
      // page 0 does not match the select: ignored
      ram_word(8'h00, 8'hFF);
      page_word({cur_select, CTRL_PAGE_NIB});
      // voice 0: half-range freq, wave table 1, full amp, hard left
      ram_word(8'h00, 8'h00);
      ram_word(8'h20, 8'h80);
      ram_word(8'h50, 8'h10);
      ram_word(8'h60, 8'h7F);
      ram_word(8'h70, 8'h08);
      // voice 1: near max freq, modulate and invert, pan code 15
      ram_word(8'h01, 8'hFE);
      ram_word(8'h11, 8'hFF);
      ram_word(8'h21, 8'hFF);
      ram_word(8'h61, 8'h40);
      ram_word(8'h71, 8'h3F);
      // bank 1 voice 2, reached when voice 1 modulates; pan all right
      ram_word(8'hA2, 8'hC0);
      ram_word(8'hF2, 8'h04);
      // negative and positive wave bytes in table 1
      page_word({cur_select, 4'h0});
      ram_word(8'h80, 8'h80);
      ram_word(8'hC0, 8'h7F);
      repeat (4) send_word(CMD_TICK, 16'hFFFF, 8'hFF);
      // control reached through the wave block path, disables voice 1
      page_word({cur_select, CTRL_ALIAS_NIB});
      ram_word(8'h01, 8'h01);
      send_word(CMD_WRITE, 16'hFFFF, 8'h00);
      send_word(CMD_WRITE, 16'h0000, 8'hFF);
      repeat (2) send_word(CMD_TICK, 16'h0000, 8'h00);

      // random phases, each with its own select and idle mix
      base_words = words_done;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               write_select(4'd15);
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
            end
            1: begin
               write_select(4'd0);
               sender_idle_pct = 67;
               rsp_stall_pct   = 0;
            end
            2: begin
               write_select(4'd5);
               sender_idle_pct = 0;
               rsp_stall_pct   = 67;
            end
            default: begin
               write_select(SELECT_RESET);
               sender_idle_pct = 16;
               rsp_stall_pct   = 16;
            end
         endcase
         run_random(base_words + RANDOM_WORDS * (p + 1) / 4);
      end

      settle(END_CYCLES);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
